// ----- hdl/csl_pkg.sv -----
// Shared types, constants and character helpers for the character stream lexer.
package csl_pkg;

  localparam int unsigned TOKEN_CHARS_DEF    = 32;
  localparam int unsigned SYMBOL_ENTRIES_DEF = 64;
  localparam int unsigned STRING_ENTRIES_DEF = 64;
  localparam int unsigned STRING_CHARS_DEF   = 32;
  localparam int unsigned ID_CHARS_DEF       = 10;

  // prefix errors allowed before the remainder is taken as the identifier
  localparam int unsigned MAX_PREFIX_ERRS = 18;
  localparam logic [7:0]  LEX_MAX         = 8'd64;
  localparam logic [15:0] LINE_MAX        = 16'hFFFF;

  localparam logic [3:0] KIND_ID        = 4'd0;
  localparam logic [3:0] KIND_INT       = 4'd1;
  localparam logic [3:0] KIND_DOUBLE    = 4'd2;
  localparam logic [3:0] KIND_STRING    = 4'd3;
  localparam logic [3:0] KIND_ASSIGN    = 4'd4;
  localparam logic [3:0] KIND_PLUS      = 4'd5;
  localparam logic [3:0] KIND_MINUS     = 4'd6;
  localparam logic [3:0] KIND_MULTI     = 4'd7;
  localparam logic [3:0] KIND_DIVISION  = 4'd8;
  localparam logic [3:0] KIND_COLON     = 4'd9;
  localparam logic [3:0] KIND_SEMICOLON = 4'd10;
  localparam logic [3:0] KIND_ERROR     = 4'd11;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  typedef enum logic [3:0] {
    L_IDLE, L_FLUSH, L_SCAN_RD, L_SCAN_CHK, L_SYM_GO, L_SYM_WAIT, L_SYM_EMIT,
    L_OP, L_STR_GO, L_STR_WAIT, L_STR_EMIT, L_STR_ERR
  } lex_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_LEN_RD, T_LEN_CHK, T_CH_RD, T_CH_CHK, T_INS_RD, T_INS_WR
  } tbl_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'd97) && (c <= 8'd122)) || ((c >= 8'd65) && (c <= 8'd90));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
  endfunction

  function automatic logic [3:0] op_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      8'd61:   k = KIND_ASSIGN;
      8'd43:   k = KIND_PLUS;
      8'd45:   k = KIND_MINUS;
      8'd42:   k = KIND_MULTI;
      8'd47:   k = KIND_DIVISION;
      8'd58:   k = KIND_COLON;
      8'd59:   k = KIND_SEMICOLON;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/csl_table.sv -----
// Interning table: entry store and length memories with a search/insert sequencer.
module csl_table #(
  parameter int unsigned ENTRIES = csl_pkg::SYMBOL_ENTRIES_DEF,
  parameter int unsigned WIDTH   = csl_pkg::ID_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [$clog2(WIDTH+1)-1:0]   key_len,
  output logic [$clog2(WIDTH+1)-1:0]   key_idx,
  input  logic [7:0]                   key_data,
  output logic                         done,
  output logic [6:0]                   slot,
  output logic                         full
);

  localparam int unsigned JW = $clog2(WIDTH + 1);
  localparam int unsigned IW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned AW = $clog2(ENTRIES * WIDTH);

  csl_pkg::tbl_state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, used_r, used_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [6:0]    slot_r, slot_nxt;
  logic          full_r, full_nxt, done_r, done_nxt;
  logic          store_we, len_we;

  logic [7:0]    store_mem [ENTRIES*WIDTH];
  logic [JW-1:0] len_mem   [ENTRIES];
  logic [7:0]    store_rd_r;
  logic [JW-1:0] len_rd_r;
  logic [AW:0]   addr_full;
  logic [AW-1:0] addr;

  assign addr_full = (AW+1)'(i_r) * (AW+1)'(WIDTH) + (AW+1)'(j_r);
  assign addr      = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    store_rd_r <= store_mem[addr];
    len_rd_r   <= len_mem[i_r[EW-1:0]];
    if (store_we) begin
      store_mem[addr] <= key_data;
    end
    if (len_we) begin
      len_mem[i_r[EW-1:0]] <= key_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csl_pkg::T_IDLE;
      used_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      done_r  <= done_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    slot_r <= slot_nxt;
    full_r <= full_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    used_nxt  = used_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    done_nxt  = 1'b0;
    store_we  = 1'b0;
    len_we    = 1'b0;
    case (state_r)
      csl_pkg::T_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          state_nxt = csl_pkg::T_LEN_RD;
        end
      end
      csl_pkg::T_LEN_RD: begin
        if (i_r == used_r) begin
          if (used_r == IW'(ENTRIES)) begin
            slot_nxt  = '0;
            full_nxt  = 1'b1;
            done_nxt  = 1'b1;
            state_nxt = csl_pkg::T_IDLE;
          end else begin
            j_nxt     = '0;
            state_nxt = csl_pkg::T_INS_RD;
          end
        end else begin
          state_nxt = csl_pkg::T_LEN_CHK;
        end
      end
      csl_pkg::T_LEN_CHK: begin
        if (len_rd_r == key_len) begin
          j_nxt     = '0;
          state_nxt = csl_pkg::T_CH_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = csl_pkg::T_LEN_RD;
        end
      end
      csl_pkg::T_CH_RD: begin
        if (j_r == key_len) begin
          slot_nxt  = 7'(i_r) + 7'd1;
          full_nxt  = 1'b0;
          done_nxt  = 1'b1;
          state_nxt = csl_pkg::T_IDLE;
        end else begin
          state_nxt = csl_pkg::T_CH_CHK;
        end
      end
      csl_pkg::T_CH_CHK: begin
        if (key_data == store_rd_r) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = csl_pkg::T_CH_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = csl_pkg::T_LEN_RD;
        end
      end
      csl_pkg::T_INS_RD: begin
        // i_r equals used_r here: the new entry goes at the end
        if (j_r == key_len) begin
          len_we    = 1'b1;
          used_nxt  = used_r + 1'b1;
          slot_nxt  = 7'(used_r) + 7'd1;
          full_nxt  = 1'b0;
          done_nxt  = 1'b1;
          state_nxt = csl_pkg::T_IDLE;
        end else begin
          state_nxt = csl_pkg::T_INS_WR;
        end
      end
      csl_pkg::T_INS_WR: begin
        store_we  = 1'b1;
        j_nxt     = j_r + 1'b1;
        state_nxt = csl_pkg::T_INS_RD;
      end
      default: state_nxt = csl_pkg::T_IDLE;
    endcase
  end

  assign key_idx = j_r;
  assign done    = done_r;
  assign slot    = slot_r;
  assign full    = full_r;

endmodule

// ----- hdl/char_stream_lexer_with_interning.sv -----
// Top level of the character stream lexer with symbol and string interning.
// An appended byte is written to the token or string buffer; a number or operator flush
// passes through the flush and operator states; an identifier flush first scans the token
// for error prefixes, then searches the symbol table; a closing quote starts a string search.
// Throughput: one byte per cycle while bytes only append; a flush is bound by the serial
// search through the table memories, plus stalls on the result register. Reset is
// synchronous, active low, clears counters and flags; buffers and tables need no clearing.
module char_stream_lexer_with_interning #(
  parameter int unsigned TOKEN_CHARS    = csl_pkg::TOKEN_CHARS_DEF,
  parameter int unsigned SYMBOL_ENTRIES = csl_pkg::SYMBOL_ENTRIES_DEF,
  parameter int unsigned STRING_ENTRIES = csl_pkg::STRING_ENTRIES_DEF,
  parameter int unsigned STRING_CHARS   = csl_pkg::STRING_CHARS_DEF,
  parameter int unsigned ID_CHARS       = csl_pkg::ID_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [6:0] table_slot, [13:7] lexeme_length,
                                  // [29:14] line_number, [31:30] zero
  output logic [4:0]  out_tuser,  // [3:0] kind, [4] table_full
  output logic        out_tlast
);

  localparam int unsigned TW   = $clog2(TOKEN_CHARS);
  localparam int unsigned TCW  = $clog2(TOKEN_CHARS + 1);
  localparam int unsigned BW   = (STRING_CHARS > 1) ? $clog2(STRING_CHARS) : 1;
  localparam int unsigned BCW  = $clog2(STRING_CHARS + 1);
  localparam int unsigned IDW  = $clog2(ID_CHARS + 1);

  csl_pkg::lex_state_t state_r, state_nxt;

  logic [7:0]     ch_r, ch_nxt;
  logic [TCW-1:0] tok_cnt_r, tok_cnt_nxt;
  logic [BCW-1:0] body_cnt_r, body_cnt_nxt;
  logic           in_str_r, in_str_nxt;
  logic [15:0]    line_r, line_nxt;
  // running classification of the pending token
  logic           all_dig_r, all_dig_nxt, dig_dot_r, dig_dot_nxt;
  logic           zero_first_r, zero_first_nxt;
  // prefix split scan
  logic [TCW-1:0] p_r, p_nxt, start_r, start_nxt;
  logic           dflag_r, dflag_nxt;
  logic [4:0]     err_r, err_nxt;
  logic [IDW-1:0] idlen_r, idlen_nxt;

  // token and string body buffers
  logic [7:0]     tok_mem  [TOKEN_CHARS];
  logic [7:0]     body_mem [STRING_CHARS];
  logic [7:0]     tok_rd_r, body_rd_r;
  logic           tok_we, body_we;
  logic [TW-1:0]  tok_raddr;
  logic [7:0]     tok_sum;
  logic [BW-1:0]  body_raddr;

  // table handshakes
  logic           sym_start, sym_done, sym_full, str_start, str_done, str_full;
  logic [6:0]     sym_slot, str_slot;
  logic [IDW-1:0] sym_idx;
  logic [BCW-1:0] str_idx;

  // result beat produced this cycle
  logic           emit;
  logic [3:0]     e_kind;
  logic [6:0]     e_slot;
  logic [7:0]     e_len;
  logic           e_full, e_last;
  logic           out_free;

  logic           out_valid_r;
  logic [3:0]     out_kind_r;
  logic [6:0]     out_slot_r, out_len_r;
  logic [15:0]    out_line_r;
  logic           out_full_r, out_last_r;

  logic [7:0]     c_in, c_tok;
  logic           blank, newline, acc;
  logic [TCW-1:0] id_diff;
  logic [15:0]    line_inc;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == csl_pkg::L_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign c_in      = in_tdata;
  assign c_tok     = tok_rd_r;
  assign blank     = csl_pkg::is_blank(ch_r);
  assign newline   = (ch_r == csl_pkg::CH_NL);
  assign id_diff   = tok_cnt_r - start_r;
  assign line_inc  = (line_r == csl_pkg::LINE_MAX) ? line_r : line_r + 16'd1;

  // scan reads walk the token; identifier interning reads from its start
  assign tok_sum   = 8'(start_r) + 8'(sym_idx);
  assign tok_raddr = ((state_r == csl_pkg::L_SCAN_RD) || (state_r == csl_pkg::L_SCAN_CHK))
                     ? p_r[TW-1:0] : tok_sum[TW-1:0];
  assign body_raddr = BW'(str_idx);

  always_ff @(posedge clk) begin
    tok_rd_r  <= tok_mem[tok_raddr];
    body_rd_r <= body_mem[body_raddr];
    if (tok_we) begin
      tok_mem[tok_cnt_r[TW-1:0]] <= c_in;
    end
    if (body_we) begin
      body_mem[body_cnt_r[BW-1:0]] <= c_in;
    end
  end

  csl_table #(.ENTRIES(SYMBOL_ENTRIES), .WIDTH(ID_CHARS)) u_sym (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sym_start),
    .key_len  (idlen_r),
    .key_idx  (sym_idx),
    .key_data (tok_rd_r),
    .done     (sym_done),
    .slot     (sym_slot),
    .full     (sym_full)
  );

  csl_table #(.ENTRIES(STRING_ENTRIES), .WIDTH(STRING_CHARS)) u_str (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (str_start),
    .key_len  (body_cnt_r),
    .key_idx  (str_idx),
    .key_data (body_rd_r),
    .done     (str_done),
    .slot     (str_slot),
    .full     (str_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csl_pkg::L_IDLE;
      tok_cnt_r   <= '0;
      body_cnt_r  <= '0;
      in_str_r    <= 1'b0;
      line_r      <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tok_cnt_r  <= tok_cnt_nxt;
      body_cnt_r <= body_cnt_nxt;
      in_str_r   <= in_str_nxt;
      line_r     <= line_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    ch_r         <= ch_nxt;
    all_dig_r    <= all_dig_nxt;
    dig_dot_r    <= dig_dot_nxt;
    zero_first_r <= zero_first_nxt;
    p_r          <= p_nxt;
    start_r      <= start_nxt;
    dflag_r      <= dflag_nxt;
    err_r        <= err_nxt;
    idlen_r      <= idlen_nxt;
    if (emit) begin
      out_kind_r <= e_kind;
      out_slot_r <= e_slot;
      out_len_r  <= (e_len > csl_pkg::LEX_MAX) ? csl_pkg::LEX_MAX[6:0] : e_len[6:0];
      out_line_r <= line_r;   // a newline's own beats carry the old line
      out_full_r <= e_full;
      out_last_r <= e_last;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    tok_cnt_nxt    = tok_cnt_r;
    body_cnt_nxt   = body_cnt_r;
    in_str_nxt     = in_str_r;
    line_nxt       = line_r;
    all_dig_nxt    = all_dig_r;
    dig_dot_nxt    = dig_dot_r;
    zero_first_nxt = zero_first_r;
    p_nxt          = p_r;
    start_nxt      = start_r;
    dflag_nxt      = dflag_r;
    err_nxt        = err_r;
    idlen_nxt      = idlen_r;
    tok_we         = 1'b0;
    body_we        = 1'b0;
    sym_start      = 1'b0;
    str_start      = 1'b0;
    emit           = 1'b0;
    e_kind         = csl_pkg::KIND_ERROR;
    e_slot         = '0;
    e_len          = '0;
    e_full         = 1'b0;
    e_last         = 1'b0;

    case (state_r)
      csl_pkg::L_IDLE: begin
        if (acc) begin
          ch_nxt = c_in;
          if (in_str_r) begin
            if (c_in == csl_pkg::CH_QUOTE) begin
              state_nxt = csl_pkg::L_STR_GO;
            end else if (c_in == csl_pkg::CH_NL) begin
              state_nxt = csl_pkg::L_STR_ERR;
            end else if (body_cnt_r < BCW'(STRING_CHARS)) begin
              body_we      = 1'b1;
              body_cnt_nxt = body_cnt_r + 1'b1;
            end
          end else if (csl_pkg::is_digit(c_in) || csl_pkg::is_alpha(c_in)
                       || (c_in == csl_pkg::CH_DOT)) begin
            // bytes past the buffer are dropped, classification included
            if (tok_cnt_r < TCW'(TOKEN_CHARS)) begin
              tok_we      = 1'b1;
              tok_cnt_nxt = tok_cnt_r + 1'b1;
              if (tok_cnt_r == '0) begin
                all_dig_nxt    = csl_pkg::is_digit(c_in);
                dig_dot_nxt    = csl_pkg::is_digit(c_in) || (c_in == csl_pkg::CH_DOT);
                zero_first_nxt = (c_in == csl_pkg::CH_ZERO);
              end else begin
                all_dig_nxt = all_dig_r && csl_pkg::is_digit(c_in);
                dig_dot_nxt = dig_dot_r &&
                              (csl_pkg::is_digit(c_in) || (c_in == csl_pkg::CH_DOT));
              end
            end
          end else if (c_in == csl_pkg::CH_QUOTE) begin
            // pending token stays counted toward the string lexeme
            in_str_nxt   = 1'b1;
            body_cnt_nxt = '0;
          end else begin
            state_nxt = csl_pkg::L_FLUSH;
          end
        end
      end

      csl_pkg::L_FLUSH: begin
        if (tok_cnt_r == '0) begin
          state_nxt = csl_pkg::L_OP;
        end else if (all_dig_r || dig_dot_r) begin
          if (out_free) begin
            emit   = 1'b1;
            e_len  = 8'(tok_cnt_r);
            e_last = blank;
            if (!all_dig_r) begin
              e_kind = csl_pkg::KIND_DOUBLE;
            end else if (zero_first_r && (tok_cnt_r > TCW'(1))) begin
              e_kind = csl_pkg::KIND_ERROR;
            end else begin
              e_kind = csl_pkg::KIND_INT;
            end
            state_nxt = csl_pkg::L_OP;
          end
        end else begin
          p_nxt     = '0;
          start_nxt = '0;
          dflag_nxt = 1'b0;
          err_nxt   = '0;
          state_nxt = csl_pkg::L_SCAN_RD;
        end
      end

      csl_pkg::L_SCAN_RD: begin
        if ((p_r == tok_cnt_r) || (err_r == 5'(csl_pkg::MAX_PREFIX_ERRS))) begin
          idlen_nxt = (8'(id_diff) > 8'(ID_CHARS)) ? IDW'(ID_CHARS) : IDW'(id_diff);
          state_nxt = csl_pkg::L_SYM_GO;
        end else begin
          state_nxt = csl_pkg::L_SCAN_CHK;
        end
      end

      csl_pkg::L_SCAN_CHK: begin
        // a letter after a digit cuts off everything before it as an error
        if (csl_pkg::is_digit(c_tok)) begin
          dflag_nxt = 1'b1;
          p_nxt     = p_r + 1'b1;
          state_nxt = csl_pkg::L_SCAN_RD;
        end else if (csl_pkg::is_alpha(c_tok) && dflag_r) begin
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = csl_pkg::KIND_ERROR;
            e_len     = 8'(p_r - start_r);
            start_nxt = p_r;
            dflag_nxt = 1'b0;
            err_nxt   = err_r + 5'd1;
            p_nxt     = p_r + 1'b1;
            state_nxt = csl_pkg::L_SCAN_RD;
          end
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = csl_pkg::L_SCAN_RD;
        end
      end

      csl_pkg::L_SYM_GO: begin
        sym_start = 1'b1;
        state_nxt = csl_pkg::L_SYM_WAIT;
      end

      csl_pkg::L_SYM_WAIT: begin
        if (sym_done) begin
          state_nxt = csl_pkg::L_SYM_EMIT;
        end
      end

      csl_pkg::L_SYM_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = csl_pkg::KIND_ID;
          e_slot    = sym_slot;
          e_len     = 8'(idlen_r);
          e_full    = sym_full;
          e_last    = blank;
          state_nxt = csl_pkg::L_OP;
        end
      end

      csl_pkg::L_OP: begin
        if (blank) begin
          tok_cnt_nxt = '0;
          if (newline) begin
            line_nxt = line_inc;
          end
          state_nxt = csl_pkg::L_IDLE;
        end else if (out_free) begin
          emit        = 1'b1;
          e_kind      = csl_pkg::op_kind(ch_r);
          e_len       = 8'd1;
          e_last      = 1'b1;
          tok_cnt_nxt = '0;
          state_nxt   = csl_pkg::L_IDLE;
        end
      end

      csl_pkg::L_STR_GO: begin
        str_start = 1'b1;
        state_nxt = csl_pkg::L_STR_WAIT;
      end

      csl_pkg::L_STR_WAIT: begin
        if (str_done) begin
          state_nxt = csl_pkg::L_STR_EMIT;
        end
      end

      csl_pkg::L_STR_EMIT: begin
        if (out_free) begin
          emit        = 1'b1;
          e_kind      = csl_pkg::KIND_STRING;
          e_slot      = str_slot;
          e_full      = str_full;
          e_len       = 8'(tok_cnt_r) + 8'(body_cnt_r) + 8'd2;
          e_last      = 1'b1;
          in_str_nxt  = 1'b0;
          tok_cnt_nxt = '0;
          state_nxt   = csl_pkg::L_IDLE;
        end
      end

      csl_pkg::L_STR_ERR: begin
        // unterminated string: consumed, reported once, line advances
        if (out_free) begin
          emit        = 1'b1;
          e_kind      = csl_pkg::KIND_ERROR;
          e_len       = 8'(tok_cnt_r) + 8'(body_cnt_r) + 8'd1;
          e_last      = 1'b1;
          in_str_nxt  = 1'b0;
          tok_cnt_nxt = '0;
          line_nxt    = line_inc;
          state_nxt   = csl_pkg::L_IDLE;
        end
      end

      default: state_nxt = csl_pkg::L_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_line_r, out_len_r, out_slot_r};
  assign out_tuser  = {out_full_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/csl_checker.sv -----
// Port-level checker for the character stream lexer, bound to the top level.
module csl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:0] <= csl_pkg::KIND_ERROR)
    else $error("result kind out of range");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |-> out_tdata[6:0] == 7'd0
      && (out_tuser[3:0] == csl_pkg::KIND_ID || out_tuser[3:0] == csl_pkg::KIND_STRING))
    else $error("table full flag on a beat without a table");

  a_line_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:30] == 2'b00 && out_tdata[29:14] != 16'd0
      && out_tdata[13:7] <= 7'd64)
    else $error("bad line number, length or padding");

endmodule

bind char_stream_lexer_with_interning csl_checker u_csl_checker (.*);
